>>> design/assert_macros.svh
// Assertion macros shared by the crossover block's modules.
// Needs a clock named clock and an active-high reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk, off while rst is high.
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Same check, on the house clock and reset names.
`define ASSERT_CLK(lbl, prop) `ASSERT_AT(lbl, clock, reset, prop)

`else

`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_CLK(lbl, prop)

`endif

`endif

>>> design/ocx_pkg.sv
// Types and fixed constants of the order crossover block.
// Used by ocx_ctrl, ocx_dp and order_crossover_with_inverse_tasks; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ocx_pkg;

   // fixed field widths
   localparam int TASK_W = 8;
   localparam int CFG_W  = 7;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // register indexes (paddr bit 2)
   localparam logic CSR_EDGES = 1'b0;
   localparam logic CSR_ARCS  = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD_INV = 2'd0,
      OP_LOAD_P1  = 2'd1,
      OP_LOAD_P2  = 2'd2,
      OP_CROSS    = 2'd3
   } ocx_op_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [TASK_W-1:0] index;
      logic [TASK_W-1:0] value;
      logic [6:0]        cut_start;
      logic [6:0]        cut_end;
   } ocx_req_type;

   typedef struct packed {
      logic [TASK_W-1:0] child_task;
      logic [6:0]        position;
      logic              last;
      logic              status;
   } ocx_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERROR,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_COPY_INV,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_WALK_INV,
      ST_EMIT_RD,
      ST_EMIT_WR
   } ocx_state_type;

   // controller -> datapath
   typedef struct packed {
      logic take;         // item accepted this cycle
      logic start_cross;  // valid cross accepted: reset marks and counters
      logic copy_wr;      // copy parent one entry into child, mark it
      logic copy_inv;     // mark inverse of copied task, advance
      logic walk_chk;     // test parent two entry, place it on a hit
      logic walk_inv;     // mark inverse of placed task, advance
      logic emit_wr;      // load child entry into the result register
      logic err_wr;       // load the error result
   } ocx_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic cross_ok;
      logic copy_last;
      logic walk_hit;
      logic walk_last;
      logic emit_last;
      logic out_free;
   } ocx_sts_type;

endpackage

`default_nettype wire

>>> design/ocx_ctrl.sv
// Sequencer of the order crossover block: accepts items and steps a cross
// through copy, walk and emit phases. Depends on ocx_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ocx_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_op,
   output logic                      req_stall,
   input  wire ocx_pkg::ocx_sts_type sts,
   output ocx_pkg::ocx_cmd_type      cmd
);
   import ocx_pkg::*;

   ocx_state_type state_ff, state_in;
   logic          cross_req;

   assign cross_req = req_valid && (req_op == OP_CROSS);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cross_req) begin
               state_in = sts.cross_ok ? ST_COPY_RD : ST_ERROR;
            end
         end
         ST_ERROR: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         ST_COPY_RD:  state_in = ST_COPY_WR;
         ST_COPY_WR:  state_in = ST_COPY_INV;
         ST_COPY_INV: state_in = sts.copy_last ? ST_WALK_RD : ST_COPY_RD;
         ST_WALK_RD:  state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (sts.walk_hit) begin
               state_in = ST_WALK_INV;
            end else begin
               state_in = sts.walk_last ? ST_EMIT_RD : ST_WALK_RD;
            end
         end
         ST_WALK_INV: state_in = sts.walk_last ? ST_EMIT_RD : ST_WALK_RD;
         ST_EMIT_RD:  state_in = ST_EMIT_WR;
         ST_EMIT_WR: begin
            if (sts.out_free) state_in = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            cmd.take        = req_valid;
            cmd.start_cross = cross_req && sts.cross_ok;
         end
         ST_ERROR:    cmd.err_wr   = sts.out_free;
         ST_COPY_WR:  cmd.copy_wr  = 1'b1;
         ST_COPY_INV: cmd.copy_inv = 1'b1;
         ST_WALK_CHK: cmd.walk_chk = 1'b1;
         ST_WALK_INV: cmd.walk_inv = 1'b1;
         ST_EMIT_WR:  cmd.emit_wr  = sts.out_free;
         default: begin
            cmd       = '0;
            req_stall = 1'b1;
         end
      endcase
   end

   // an accepted cross always leaves idle
   `ASSERT_CLK(a_cross_leaves_idle,
      (state_ff == ST_IDLE && cross_req) |=> (state_ff != ST_IDLE))
   // inverse marking in the walk follows a placed task only
   `ASSERT_CLK(a_walk_inv_after_hit,
      (state_ff == ST_WALK_INV) |-> ($past(state_ff) == ST_WALK_CHK && $past(sts.walk_hit)))
   // a blocked result waits in place
   `ASSERT_CLK(a_emit_waits,
      (state_ff == ST_EMIT_WR && !sts.out_free) |=> (state_ff == ST_EMIT_WR))

endmodule

`default_nettype wire

>>> design/ocx_dp.sv
// Datapath of the order crossover block: inverse and parent memories, child
// buffer, used marks, walk counters and the result register. Depends on ocx_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ocx_dp #(
   parameter int MAX_SEQ     = 64,
   parameter int MAX_TASK_ID = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ocx_pkg::ocx_req_type  req_data,
   input  wire logic [6:0]            cfg_edges,
   input  wire logic [6:0]            cfg_arcs,
   input  wire ocx_pkg::ocx_cmd_type  cmd,
   output ocx_pkg::ocx_sts_type       sts,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output ocx_pkg::ocx_rsp_type       rsp_data
);
   import ocx_pkg::*;

   localparam int SEQ_AW = $clog2(MAX_SEQ);
   localparam int POS_W  = $clog2(MAX_SEQ + 1);
   localparam int INV_AW = $clog2(MAX_TASK_ID);
   localparam logic [8:0]        ID_LIMIT  = 9'(MAX_TASK_ID);
   localparam logic [TASK_W-1:0] SEQ_LIMIT = TASK_W'(MAX_SEQ);

   // memories
   logic [TASK_W-1:0] inv_mem   [MAX_TASK_ID];
   logic [TASK_W-1:0] p1_mem    [MAX_SEQ];
   logic [TASK_W-1:0] p2_mem    [MAX_SEQ];
   logic [TASK_W-1:0] child_mem [MAX_SEQ];

   logic [TASK_W-1:0]      inv_rd_ff, p1_rd_ff, p2_rd_ff, child_rd_ff;
   logic                   child_rd_vld_ff;
   logic [MAX_SEQ-1:0]     child_vld_ff;
   logic [MAX_TASK_ID-1:0] unused_ff;

   logic [SEQ_AW-1:0] pos_ff, i_ff, j_ff, cnt_ff;
   logic [POS_W-1:0]  q_ff, tau_ff;

   logic              rsp_valid_ff;
   ocx_rsp_type       rsp_ff;

   logic [7:0]        tau_sum;
   logic [POS_W-1:0]  tau_new, q_new;
   logic [SEQ_AW-1:0] start_new;
   logic              we_inv, we_p1, we_p2, we_child, step;
   logic [SEQ_AW-1:0] ld_addr, child_waddr;
   logic [TASK_W-1:0] child_wdata, inv_raddr, mark_id;
   logic              mark_en;

   function automatic logic id_ok(input logic [TASK_W-1:0] id);
      return {1'b0, id} < ID_LIMIT;
   endfunction

   // next position around a sequence of tau_ff entries
   function automatic logic [SEQ_AW-1:0] cyc_inc(input logic [SEQ_AW-1:0] x);
      return (POS_W'(x) + POS_W'(1) == tau_ff) ? '0 : x + SEQ_AW'(1);
   endfunction

   // task count and walk start of a new cross
   always_comb begin
      tau_sum   = {1'b0, cfg_edges} + {1'b0, cfg_arcs};
      tau_new   = POS_W'(tau_sum);
      q_new     = POS_W'(req_data.cut_end);
      start_new = (q_new == tau_new) ? '0 : SEQ_AW'(q_new);
   end

   // load decode
   assign ld_addr = SEQ_AW'(req_data.index - 8'd1);
   assign we_inv  = cmd.take && (req_data.operation == OP_LOAD_INV) && id_ok(req_data.index);
   assign we_p1   = cmd.take && (req_data.operation == OP_LOAD_P1)
                    && (req_data.index != 8'd0) && (req_data.index <= SEQ_LIMIT);
   assign we_p2   = cmd.take && (req_data.operation == OP_LOAD_P2)
                    && (req_data.index != 8'd0) && (req_data.index <= SEQ_LIMIT);

   // status, with the cut point check against the configured task count
   always_comb begin
      sts.cross_ok  = (tau_sum != 8'd0) && (tau_sum <= SEQ_LIMIT)
                      && (req_data.cut_start != 7'd0)
                      && (req_data.cut_end >= req_data.cut_start)
                      && ({1'b0, req_data.cut_end} <= tau_sum);
      sts.walk_hit  = id_ok(p2_rd_ff) && unused_ff[p2_rd_ff[INV_AW-1:0]];
      sts.copy_last = (POS_W'(pos_ff) + POS_W'(1) == q_ff);
      sts.walk_last = (POS_W'(cnt_ff) + POS_W'(1) == tau_ff);
      sts.emit_last = (POS_W'(pos_ff) + POS_W'(1) == tau_ff);
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // child write, inverse lookup and used marking
   always_comb begin
      we_child    = cmd.copy_wr || (cmd.walk_chk && sts.walk_hit);
      child_waddr = cmd.copy_wr ? pos_ff : j_ff;
      child_wdata = cmd.copy_wr ? p1_rd_ff : p2_rd_ff;
      inv_raddr   = cmd.walk_chk ? p2_rd_ff : p1_rd_ff;
      step        = (cmd.walk_chk && !sts.walk_hit) || cmd.walk_inv;
      mark_id     = '0;
      mark_en     = 1'b0;
      if (cmd.copy_wr) begin
         mark_id = p1_rd_ff;
      end else if (cmd.copy_inv) begin
         // an out of range task has inverse id zero
         mark_id = id_ok(p1_rd_ff) ? inv_rd_ff : '0;
      end else if (cmd.walk_chk) begin
         mark_id = p2_rd_ff;
      end else if (cmd.walk_inv) begin
         mark_id = inv_rd_ff;
      end
      if (cmd.copy_wr || cmd.copy_inv || cmd.walk_inv
          || (cmd.walk_chk && sts.walk_hit)) begin
         mark_en = id_ok(mark_id);
      end
   end

   // inverse table
   always_ff @(posedge clock) begin
      if (we_inv) inv_mem[req_data.index[INV_AW-1:0]] <= req_data.value;
      inv_rd_ff <= inv_mem[inv_raddr[INV_AW-1:0]];
   end

   // parent sequences
   always_ff @(posedge clock) begin
      if (we_p1) p1_mem[ld_addr] <= req_data.value;
      if (we_p2) p2_mem[ld_addr] <= req_data.value;
      p1_rd_ff <= p1_mem[pos_ff];
      p2_rd_ff <= p2_mem[i_ff];
   end

   // child buffer
   always_ff @(posedge clock) begin
      if (we_child) child_mem[child_waddr] <= child_wdata;
      child_rd_ff     <= child_mem[pos_ff];
      child_rd_vld_ff <= child_vld_ff[pos_ff];
   end

   // child entries never written since the cross read as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.start_cross) begin
         child_vld_ff <= '0;
      end else if (we_child) begin
         child_vld_ff[child_waddr] <= 1'b1;
      end
   end

   // used marks, all free at reset and at each cross
   always_ff @(posedge clock) begin
      if (reset || cmd.start_cross) begin
         unused_ff <= '1;
      end else if (mark_en) begin
         unused_ff[mark_id[INV_AW-1:0]] <= 1'b0;
      end
   end

   // position counters
   always_ff @(posedge clock) begin
      if (cmd.start_cross) begin
         pos_ff <= SEQ_AW'(req_data.cut_start - 7'd1);
         q_ff   <= q_new;
         tau_ff <= tau_new;
         i_ff   <= start_new;
         j_ff   <= start_new;
         cnt_ff <= '0;
      end else begin
         if (cmd.copy_inv) pos_ff <= sts.copy_last ? '0 : pos_ff + SEQ_AW'(1);
         if (cmd.emit_wr)  pos_ff <= pos_ff + SEQ_AW'(1);
         if (step) begin
            i_ff   <= cyc_inc(i_ff);
            cnt_ff <= cnt_ff + SEQ_AW'(1);
         end
         if (cmd.walk_inv) j_ff <= cyc_inc(j_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_wr || cmd.err_wr) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.err_wr) begin
         rsp_ff.child_task <= '0;
         rsp_ff.position   <= '0;
         rsp_ff.last       <= 1'b1;
         rsp_ff.status     <= 1'b1;
      end else if (cmd.emit_wr) begin
         rsp_ff.child_task <= child_rd_vld_ff ? child_rd_ff : '0;
         rsp_ff.position   <= 7'(POS_W'(pos_ff) + POS_W'(1));
         rsp_ff.last       <= sts.emit_last;
         rsp_ff.status     <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an error result closes its run
   `ASSERT_CLK(a_err_is_last, rsp_valid_ff |-> (!rsp_ff.status || rsp_ff.last))
   // copying stays inside the cut
   `ASSERT_CLK(a_copy_in_cut, cmd.copy_wr |-> (POS_W'(pos_ff) < q_ff))
   // walk pointers stay inside the sequence
   `ASSERT_CLK(a_walk_in_seq,
      cmd.walk_chk |-> (POS_W'(i_ff) < tau_ff && POS_W'(j_ff) < tau_ff))
   // a cross starts with every task free
   `ASSERT_CLK(a_marks_cleared, cmd.start_cross |=> (&unused_ff))

endmodule

`default_nettype wire

>>> design/order_crossover_with_inverse_tasks.sv
// Order crossover block with inverse task exclusion: top level, CSR port.
// Depends on ocx_pkg, ocx_ctrl and ocx_dp.
//
// Usage: load items (operation 0..2) write the inverse table and the two
// parent sequences, one item per cycle while idle, and give no result.
// A cross item (operation 3) with cut points p..q yields tau = edges + arcs
// results, positions 1..tau in order, last set on the final one; bad cut
// points or a bad tau give a single result with status 1 and last 1.
// Steps: a cross is accepted in idle; each copied position is read, written
// into the child and its inverse marked; each parent two entry is read and
// checked, and a placed one has its inverse marked; each result is then read
// from the child buffer and loaded into the result register, waiting while
// the output is stalled. Every step waits on one registered read of the
// parent, inverse or child memory. req_stall stays high while a cross runs.
// A bad cross passes through the error state, which loads the error result.
// Reset clears the configuration registers, the used marks and the child
// buffer; the inverse and parent memories hold nothing until loaded.
// A stalled result is held in the output register and the sequence waits.
`timescale 1ns / 1ps
`default_nettype none

module order_crossover_with_inverse_tasks #(
   parameter int MAX_SEQ     = 64,
   parameter int MAX_TASK_ID = 256
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire ocx_pkg::ocx_req_type        req_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output ocx_pkg::ocx_rsp_type             rsp_data,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [ocx_pkg::CSR_AW-1:0]  csr_paddr,
   input  wire logic [ocx_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ocx_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                             csr_pready
);
   import ocx_pkg::*;

   logic [CFG_W-1:0] edges_ff, arcs_ff;
   logic             csr_wr;
   ocx_cmd_type      cmd;
   ocx_sts_type      sts;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_ff <= '0;
         arcs_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == CSR_EDGES) edges_ff <= csr_pwdata[CFG_W-1:0];
         if (csr_paddr[2] == CSR_ARCS)  arcs_ff  <= csr_pwdata[CFG_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_ARCS) ? CSR_DW'(arcs_ff) : CSR_DW'(edges_ff);

   // sequencer
   ocx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage and result path
   ocx_dp #(
      .MAX_SEQ     (MAX_SEQ),
      .MAX_TASK_ID (MAX_TASK_ID)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg_edges (edges_ff),
      .cfg_arcs  (arcs_ff),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
